/* src/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, token codes, character constants and lookup functions of the
// source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int OFFSET_BITS_DEF       = 20;
  localparam int ROW_BITS_DEF          = 16;
  localparam int COL_BITS_DEF          = 16;
  localparam int MAX_COMMENT_DEPTH_DEF = 15;

  // Widths of the result fields on the token channel.
  localparam int KIND_W = 5;
  localparam int OFF_W  = 20;
  localparam int ROW_W  = 16;
  localparam int COL_W  = 16;

  localparam int FIFO_DEPTH = 4;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  typedef enum logic [KIND_W-1:0] {
    TK_EOF, TK_LPAREN, TK_RPAREN, TK_LBRACE, TK_RBRACE, TK_PLUS, TK_MINUS,
    TK_STAR, TK_SEMI, TK_SLASH, TK_GT, TK_GE, TK_LT, TK_LE, TK_NOT, TK_NE,
    TK_ASSIGN, TK_EQ, TK_COLON, TK_DEFINE, TK_STRING, TK_INT, TK_IDENT,
    TK_TRUE, TK_FALSE, TK_AND, TK_OR, TK_PRINT, TK_ELSE, TK_IF, TK_BAD_STRING
  } tok_kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_SLASH, MODE_OP2, MODE_STRING, MODE_INT, MODE_IDENT,
    MODE_LINE, MODE_BLOCK
  } scan_mode_e;

  typedef enum logic [2:0] {
    KW_NONE, KW_TRUE, KW_FALSE, KW_AND, KW_OR, KW_PRINT, KW_ELSE, KW_IF
  } kw_sel_e;

  typedef struct packed {
    tok_kind_e          kind;
    logic [OFF_W-1:0]   start_offset;
    logic [OFF_W-1:0]   token_length;
    logic [ROW_W-1:0]   start_row;
    logic [COL_W-1:0]   start_col;
    logic [ROW_W-1:0]   end_row;
    logic [COL_W-1:0]   end_col;
    logic               last_of_run;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } tok_push_t;

  function automatic logic is_digit(logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_word(logic [7:0] b);
    return b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], 8'h5F};
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return b inside {CH_SPACE, CH_TAB, CH_NL};
  endfunction

  function automatic tok_kind_e single_op_kind(logic [7:0] b);
    tok_kind_e k;
    case (b)
      8'h28:   k = TK_LPAREN;
      8'h29:   k = TK_RPAREN;
      8'h7B:   k = TK_LBRACE;
      8'h7D:   k = TK_RBRACE;
      8'h2B:   k = TK_PLUS;
      8'h2D:   k = TK_MINUS;
      8'h2A:   k = TK_STAR;
      8'h3B:   k = TK_SEMI;
      default: k = TK_EOF;
    endcase
    return k;
  endfunction

  function automatic tok_kind_e pair_op_kind(logic [7:0] b);
    tok_kind_e k;
    case (b)
      8'h3E:   k = TK_GT;
      8'h3C:   k = TK_LT;
      8'h21:   k = TK_NOT;
      8'h3D:   k = TK_ASSIGN;
      8'h3A:   k = TK_COLON;
      default: k = TK_EOF;
    endcase
    return k;
  endfunction

  function automatic tok_kind_e pair_eq_kind(logic [7:0] b);
    tok_kind_e k;
    case (b)
      8'h3E:   k = TK_GE;
      8'h3C:   k = TK_LE;
      8'h21:   k = TK_NE;
      8'h3D:   k = TK_EQ;
      8'h3A:   k = TK_DEFINE;
      default: k = TK_EOF;
    endcase
    return k;
  endfunction

  function automatic kw_sel_e kw_first(logic [7:0] b);
    kw_sel_e c;
    case (b)
      8'h74:   c = KW_TRUE;
      8'h66:   c = KW_FALSE;
      8'h61:   c = KW_AND;
      8'h6F:   c = KW_OR;
      8'h70:   c = KW_PRINT;
      8'h65:   c = KW_ELSE;
      8'h69:   c = KW_IF;
      default: c = KW_NONE;
    endcase
    return c;
  endfunction

  // Number of keyword bytes after the first one.
  function automatic logic [2:0] kw_rest_len(kw_sel_e c);
    logic [2:0] n;
    case (c)
      KW_TRUE:  n = 3'd3;
      KW_FALSE: n = 3'd4;
      KW_AND:   n = 3'd2;
      KW_OR:    n = 3'd1;
      KW_PRINT: n = 3'd4;
      KW_ELSE:  n = 3'd3;
      KW_IF:    n = 3'd1;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

  // Byte at position idx of the keyword tail, left-justified in a word.
  function automatic logic [7:0] kw_rest_char(kw_sel_e c, logic [1:0] idx);
    logic [31:0] w;
    case (c)
      KW_TRUE:  w = {"rue", 8'h00};
      KW_FALSE: w = "alse";
      KW_AND:   w = {"nd", 16'h0000};
      KW_OR:    w = {"r", 24'h000000};
      KW_PRINT: w = "rint";
      KW_ELSE:  w = {"lse", 8'h00};
      KW_IF:    w = {"f", 24'h000000};
      default:  w = 32'h0;
    endcase
    return w[31 - 8*idx -: 8];
  endfunction

  function automatic tok_kind_e kw_kind(kw_sel_e c);
    tok_kind_e k;
    case (c)
      KW_TRUE:  k = TK_TRUE;
      KW_FALSE: k = TK_FALSE;
      KW_AND:   k = TK_AND;
      KW_OR:    k = TK_OR;
      KW_PRINT: k = TK_PRINT;
      KW_ELSE:  k = TK_ELSE;
      KW_IF:    k = TK_IF;
      default:  k = TK_IDENT;
    endcase
    return k;
  endfunction

endpackage

/* src/stt_byte_if.sv */
// ----------------------------------------------------------------------------
// stt_byte_if
// Valid/ready channel that carries one source text byte per transfer.
// ----------------------------------------------------------------------------
interface stt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

/* src/stt_token_if.sv */
// ----------------------------------------------------------------------------
// stt_token_if
// Valid/ready channel that carries one token per transfer.
// ----------------------------------------------------------------------------
interface stt_token_if;
  logic                       valid;
  logic                       ready;
  logic [stt_pkg::KIND_W-1:0] token_kind;
  logic [stt_pkg::OFF_W-1:0]  start_offset;
  logic [stt_pkg::OFF_W-1:0]  token_length;
  logic [stt_pkg::ROW_W-1:0]  start_row;
  logic [stt_pkg::COL_W-1:0]  start_col;
  logic [stt_pkg::ROW_W-1:0]  end_row;
  logic [stt_pkg::COL_W-1:0]  end_col;
  logic                       last_of_run;

  modport source (
    output valid, output token_kind, output start_offset, output token_length,
    output start_row, output start_col, output end_row, output end_col,
    output last_of_run, input ready
  );
  modport sink (
    input valid, input token_kind, input start_offset, input token_length,
    input start_row, input start_col, input end_row, input end_col,
    input last_of_run, output ready
  );
endinterface

/* src/source_text_tokenizer.sv */
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexer: one source byte in per transfer, tokens out as they close.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle and updates its scanner state in
// the same cycle; each byte yields zero, one or two tokens, which enter a
// four-entry token queue and appear on the token channel from the next cycle
// on, one token per cycle with the channel ready. A byte is taken whenever
// the queue has room for two tokens, so with the channel ready the sustained
// rate is one byte per cycle; it drops only when bytes produce tokens faster
// than one per cycle, which the single read port of the token queue sets.
module source_text_tokenizer #(
  parameter int OFFSET_BITS       = stt_pkg::OFFSET_BITS_DEF,
  parameter int ROW_BITS          = stt_pkg::ROW_BITS_DEF,
  parameter int COL_BITS          = stt_pkg::COL_BITS_DEF,
  parameter int MAX_COMMENT_DEPTH = stt_pkg::MAX_COMMENT_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stt_byte_if.sink    text_i,
  stt_token_if.source token_o
);

  localparam int DEPTH_W = $clog2(MAX_COMMENT_DEPTH + 1);

  localparam logic [stt_pkg::OFF_W-1:0] OFF_MAX = '1;
  localparam logic [stt_pkg::ROW_W-1:0] ROW_MAX = '1;
  localparam logic [stt_pkg::COL_W-1:0] COL_MAX = '1;

  stt_pkg::scan_mode_e    mode_q, mode_d;
  logic [7:0]             pfb_q, pfb_d;
  stt_pkg::kw_sel_e       kc_q, kc_d;
  logic                   km_q, km_d;
  logic [DEPTH_W-1:0]     depth_q, depth_d;
  logic [OFFSET_BITS-1:0] bo_q, bo_d, tso_q, tso_d;
  logic [ROW_BITS-1:0]    row_q, row_d, tsr_q, tsr_d;
  logic [COL_BITS-1:0]    col_q, col_d, tsc_q, tsc_d;

  logic                   accept, room;
  logic [7:0]             b;
  logic                   eot;

  logic [OFFSET_BITS-1:0] bo_c, tok_len;
  logic [ROW_BITS-1:0]    row_c;
  logic [COL_BITS-1:0]    col_c;

  stt_pkg::scan_mode_e    fr_mode;
  logic [7:0]             fr_pfb;
  stt_pkg::kw_sel_e       fr_kc;
  stt_pkg::tok_kind_e     fr_single, ident_kind;
  logic                   kw_step_ok;

  logic                   close_v, post_v, new_v;
  stt_pkg::tok_kind_e     close_kind, post_kind, new_kind;
  stt_pkg::token_t        close_tok, post_tok, new_tok;
  stt_pkg::tok_push_t     push;

  function automatic logic [stt_pkg::OFF_W-1:0] cap_off(logic [OFFSET_BITS-1:0] v);
    logic [31:0] e;
    e = 32'(v);
    return (e > 32'(OFF_MAX)) ? OFF_MAX : e[stt_pkg::OFF_W-1:0];
  endfunction

  function automatic logic [stt_pkg::ROW_W-1:0] cap_row(logic [ROW_BITS-1:0] v);
    logic [31:0] e;
    e = 32'(v);
    return (e > 32'(ROW_MAX)) ? ROW_MAX : e[stt_pkg::ROW_W-1:0];
  endfunction

  function automatic logic [stt_pkg::COL_W-1:0] cap_col(logic [COL_BITS-1:0] v);
    logic [31:0] e;
    e = 32'(v);
    return (e > 32'(COL_MAX)) ? COL_MAX : e[stt_pkg::COL_W-1:0];
  endfunction

  function automatic stt_pkg::token_t make_token(
    stt_pkg::tok_kind_e k,
    logic [OFFSET_BITS-1:0] s_off, logic [OFFSET_BITS-1:0] e_off,
    logic [ROW_BITS-1:0] s_row, logic [COL_BITS-1:0] s_col,
    logic [ROW_BITS-1:0] e_row, logic [COL_BITS-1:0] e_col,
    logic last
  );
    stt_pkg::token_t t;
    t.kind         = k;
    t.start_offset = cap_off(s_off);
    t.token_length = cap_off(e_off - s_off);
    t.start_row    = cap_row(s_row);
    t.start_col    = cap_col(s_col);
    t.end_row      = cap_row(e_row);
    t.end_col      = cap_col(e_col);
    t.last_of_run  = last;
    return t;
  endfunction

  assign b           = text_i.text_byte;
  assign eot         = text_i.end_of_text;
  assign text_i.ready = room;
  assign accept      = text_i.valid && room;

  // Position after consuming the incoming byte; all counters saturate.
  always_comb begin
    bo_c    = (bo_q == '1) ? bo_q : bo_q + OFFSET_BITS'(1);
    tok_len = bo_q - tso_q;
    if (b == stt_pkg::CH_NL) begin
      row_c = (row_q == '1) ? row_q : row_q + ROW_BITS'(1);
      col_c = COL_BITS'(1);
    end else begin
      row_c = row_q;
      col_c = (col_q == '1) ? col_q : col_q + COL_BITS'(1);
    end
  end

  // Classification of a byte that starts a new token.
  always_comb begin
    fr_single = stt_pkg::single_op_kind(b);
    fr_pfb    = 8'h00;
    fr_kc     = stt_pkg::KW_NONE;
    if (stt_pkg::is_space(b) || fr_single != stt_pkg::TK_EOF) begin
      fr_mode = stt_pkg::MODE_IDLE;
    end else if (b == stt_pkg::CH_SLASH) begin
      fr_mode = stt_pkg::MODE_SLASH;
    end else if (stt_pkg::pair_op_kind(b) != stt_pkg::TK_EOF) begin
      fr_mode = stt_pkg::MODE_OP2;
      fr_pfb  = b;
    end else if (b == stt_pkg::CH_QUOTE) begin
      fr_mode = stt_pkg::MODE_STRING;
    end else if (stt_pkg::is_digit(b)) begin
      fr_mode = stt_pkg::MODE_INT;
    end else begin
      fr_mode = stt_pkg::MODE_IDENT;
      fr_kc   = stt_pkg::kw_first(b);
    end
  end

  // Keyword tracking for identifiers.
  always_comb begin
    if (kc_q != stt_pkg::KW_NONE && km_q &&
        tok_len == OFFSET_BITS'(stt_pkg::kw_rest_len(kc_q)) + OFFSET_BITS'(1)) begin
      ident_kind = stt_pkg::kw_kind(kc_q);
    end else begin
      ident_kind = stt_pkg::TK_IDENT;
    end
    kw_step_ok = (tok_len != '0) &&
                 (tok_len <= OFFSET_BITS'(stt_pkg::kw_rest_len(kc_q))) &&
                 (b == stt_pkg::kw_rest_char(kc_q, 2'(tok_len - OFFSET_BITS'(1))));
  end

  // Next state.
  always_comb begin
    logic do_fresh;
    logic do_consume;
    do_fresh   = 1'b0;
    do_consume = 1'b0;
    mode_d  = mode_q;
    pfb_d   = pfb_q;
    kc_d    = kc_q;
    km_d    = km_q;
    depth_d = depth_q;
    bo_d    = bo_q;
    tso_d   = tso_q;
    row_d   = row_q;
    tsr_d   = tsr_q;
    col_d   = col_q;
    tsc_d   = tsc_q;
    if (accept && eot) begin
      mode_d  = stt_pkg::MODE_IDLE;
      pfb_d   = 8'h00;
      kc_d    = stt_pkg::KW_NONE;
      km_d    = 1'b0;
      depth_d = '0;
      bo_d    = '0;
      tso_d   = '0;
      row_d   = ROW_BITS'(1);
      tsr_d   = ROW_BITS'(1);
      col_d   = '0;
      tsc_d   = '0;
    end else if (accept) begin
      case (mode_q)
        stt_pkg::MODE_SLASH: begin
          if (b == stt_pkg::CH_SLASH) begin
            do_consume = 1'b1;
            mode_d     = stt_pkg::MODE_LINE;
          end else if (b == stt_pkg::CH_STAR) begin
            do_consume = 1'b1;
            mode_d     = stt_pkg::MODE_BLOCK;
            depth_d    = DEPTH_W'(1);
            pfb_d      = 8'h00;
          end else begin
            do_fresh = 1'b1;
          end
        end
        stt_pkg::MODE_OP2: begin
          if (b == stt_pkg::CH_EQ) begin
            do_consume = 1'b1;
            pfb_d      = 8'h00;
            mode_d     = stt_pkg::MODE_IDLE;
          end else begin
            do_fresh = 1'b1;
          end
        end
        stt_pkg::MODE_STRING: begin
          do_consume = 1'b1;
          if (b == stt_pkg::CH_QUOTE) begin
            mode_d = stt_pkg::MODE_IDLE;
          end
        end
        stt_pkg::MODE_INT: begin
          if (stt_pkg::is_digit(b)) begin
            do_consume = 1'b1;
          end else begin
            do_fresh = 1'b1;
          end
        end
        stt_pkg::MODE_IDENT: begin
          if (stt_pkg::is_word(b)) begin
            do_consume = 1'b1;
            if (km_q && !kw_step_ok) begin
              km_d = 1'b0;
            end
          end else begin
            do_fresh = 1'b1;
          end
        end
        stt_pkg::MODE_LINE: begin
          do_consume = 1'b1;
          if (b == stt_pkg::CH_NL) begin
            mode_d = stt_pkg::MODE_IDLE;
          end
        end
        stt_pkg::MODE_BLOCK: begin
          do_consume = 1'b1;
          if (pfb_q == stt_pkg::CH_SLASH && b == stt_pkg::CH_STAR) begin
            if (depth_q < DEPTH_W'(MAX_COMMENT_DEPTH)) begin
              depth_d = depth_q + DEPTH_W'(1);
            end
            pfb_d = 8'h00;
          end else if (pfb_q == stt_pkg::CH_STAR && b == stt_pkg::CH_SLASH) begin
            pfb_d = 8'h00;
            if (depth_q <= DEPTH_W'(1)) begin
              depth_d = '0;
              mode_d  = stt_pkg::MODE_IDLE;
            end else begin
              depth_d = depth_q - DEPTH_W'(1);
            end
          end else if (b == stt_pkg::CH_SLASH || b == stt_pkg::CH_STAR) begin
            pfb_d = b;
          end else begin
            pfb_d = 8'h00;
          end
        end
        default: begin
          do_fresh = 1'b1;
        end
      endcase
      if (do_fresh) begin
        tso_d  = bo_q;
        tsr_d  = row_q;
        tsc_d  = col_q;
        mode_d = fr_mode;
        pfb_d  = fr_pfb;
        kc_d   = fr_kc;
        km_d   = fr_kc != stt_pkg::KW_NONE;
      end
      if (do_fresh || do_consume) begin
        bo_d  = bo_c;
        row_d = row_c;
        col_d = col_c;
      end
    end
  end

  // Tokens produced by the incoming byte.
  always_comb begin
    close_v    = 1'b0;
    post_v     = 1'b0;
    new_v      = 1'b0;
    close_kind = stt_pkg::TK_EOF;
    post_kind  = stt_pkg::TK_EOF;
    new_kind   = stt_pkg::TK_EOF;
    case (mode_q)
      stt_pkg::MODE_SLASH:  close_kind = stt_pkg::TK_SLASH;
      stt_pkg::MODE_OP2:    close_kind = stt_pkg::pair_op_kind(pfb_q);
      stt_pkg::MODE_STRING: close_kind = stt_pkg::TK_BAD_STRING;
      stt_pkg::MODE_INT:    close_kind = stt_pkg::TK_INT;
      stt_pkg::MODE_IDENT:  close_kind = ident_kind;
      default:              close_kind = stt_pkg::TK_EOF;
    endcase
    if (eot) begin
      close_v = mode_q == stt_pkg::MODE_SLASH || mode_q == stt_pkg::MODE_OP2 ||
                mode_q == stt_pkg::MODE_STRING || mode_q == stt_pkg::MODE_INT ||
                mode_q == stt_pkg::MODE_IDENT;
      new_v   = 1'b1;
    end else begin
      case (mode_q)
        stt_pkg::MODE_SLASH:
          close_v = b != stt_pkg::CH_SLASH && b != stt_pkg::CH_STAR;
        stt_pkg::MODE_OP2: begin
          close_v   = b != stt_pkg::CH_EQ;
          post_v    = b == stt_pkg::CH_EQ;
          post_kind = stt_pkg::pair_eq_kind(pfb_q);
        end
        stt_pkg::MODE_STRING: begin
          post_v    = b == stt_pkg::CH_QUOTE;
          post_kind = stt_pkg::TK_STRING;
        end
        stt_pkg::MODE_INT:   close_v = !stt_pkg::is_digit(b);
        stt_pkg::MODE_IDENT: close_v = !stt_pkg::is_word(b);
        default:             close_v = 1'b0;
      endcase
      // A fresh scan follows a closed token, and starts from idle directly.
      if (close_v || mode_q == stt_pkg::MODE_IDLE) begin
        new_v    = fr_single != stt_pkg::TK_EOF;
        new_kind = fr_single;
      end
    end

    close_tok = make_token(close_kind, tso_q, bo_q, tsr_q, tsc_q, row_q, col_q, !new_v);
    post_tok  = make_token(post_kind, tso_q, bo_c, tsr_q, tsc_q, row_c, col_c, 1'b1);
    new_tok   = make_token(new_kind, bo_q, eot ? bo_q : bo_c, row_q, col_q,
                           eot ? row_q : row_c, eot ? col_q : col_c, 1'b1);

    push.second = new_tok;
    if (close_v) begin
      push.first = close_tok;
    end else if (post_v) begin
      push.first = post_tok;
    end else begin
      push.first = new_tok;
    end
    push.count = accept ? (2'(close_v) + 2'(post_v) + 2'(new_v)) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= stt_pkg::MODE_IDLE;
      pfb_q   <= 8'h00;
      kc_q    <= stt_pkg::KW_NONE;
      km_q    <= 1'b0;
      depth_q <= '0;
      bo_q    <= '0;
      tso_q   <= '0;
      row_q   <= ROW_BITS'(1);
      tsr_q   <= ROW_BITS'(1);
      col_q   <= '0;
      tsc_q   <= '0;
    end else begin
      mode_q  <= mode_d;
      pfb_q   <= pfb_d;
      kc_q    <= kc_d;
      km_q    <= km_d;
      depth_q <= depth_d;
      bo_q    <= bo_d;
      tso_q   <= tso_d;
      row_q   <= row_d;
      tsr_q   <= tsr_d;
      col_q   <= col_d;
      tsc_q   <= tsc_d;
    end
  end

  stt_token_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .token_o (token_o)
  );

  a_depth_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == stt_pkg::MODE_BLOCK) |-> (depth_q != '0))
    else $error("block comment open with zero depth");

  a_depth_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != stt_pkg::MODE_BLOCK) |-> (depth_q == '0))
    else $error("comment depth left over outside block comment");

  a_pfb_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pfb_q != 8'h00) |-> (mode_q == stt_pkg::MODE_OP2 || mode_q == stt_pkg::MODE_BLOCK))
    else $error("pending byte held outside operator or comment scan");

  a_start_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tso_q <= bo_q)
    else $error("token start beyond current offset");

endmodule

/* src/stt_token_fifo.sv */
// ----------------------------------------------------------------------------
// stt_token_fifo
// Small token queue: takes up to two tokens per cycle, hands out one while ready.
// ----------------------------------------------------------------------------
module stt_token_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stt_pkg::tok_push_t push_i,
  output logic               room_o,
  stt_token_if.source        token_o
);

  localparam int PTR_W = $clog2(stt_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(stt_pkg::FIFO_DEPTH + 1);

  stt_pkg::token_t  mem_q [stt_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;
  stt_pkg::token_t  head;

  assign pop    = token_o.valid && token_o.ready;
  assign room_o = cnt_q <= CNT_W'(stt_pkg::FIFO_DEPTH - 2);

  always_comb begin
    wr_d  = wr_q + PTR_W'(push_i.count);
    rd_d  = rd_q + PTR_W'(pop);
    cnt_d = cnt_q + CNT_W'(push_i.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[PTR_W'(wr_q + 1'b1)] <= push_i.second;
    end
  end

  assign head                 = mem_q[rd_q];
  assign token_o.valid        = cnt_q != '0;
  assign token_o.token_kind   = head.kind;
  assign token_o.start_offset = head.start_offset;
  assign token_o.token_length = head.token_length;
  assign token_o.start_row    = head.start_row;
  assign token_o.start_col    = head.start_col;
  assign token_o.end_row      = head.end_row;
  assign token_o.end_col      = head.end_col;
  assign token_o.last_of_run  = head.last_of_run;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(stt_pkg::FIFO_DEPTH))
    else $error("token queue count out of range");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> room_o)
    else $error("token pushed without room");

  a_pair_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count == 2'd2) |-> (push_i.second.last_of_run && !push_i.first.last_of_run))
    else $error("last_of_run misplaced in token pair");

endmodule
